### design/srd_pkg.sv
// ----------------------------------------------------------------------------
// srd_pkg
// Shared types, constants and the crc-8 update for the response deframer.
// ----------------------------------------------------------------------------
package srd_pkg;

    localparam logic [7:0] FLAG_BYTE = 8'h7E;
    localparam logic [7:0] ESC_BYTE  = 8'h7D;
    localparam logic [7:0] ESC_MASK  = 8'h20;
    localparam logic [7:0] CRC_INIT  = 8'hFF;
    localparam logic [7:0] CRC_POLY  = 8'h31;

    localparam int RX_W    = 8;
    localparam int M_DATA_W = 32;
    localparam int CFG_IDX_W = 1;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_ADDR,
        PH_CMD,
        PH_STATE,
        PH_LEN,
        PH_DATA,
        PH_CHECK,
        PH_STOP
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_ADDR     = 3'd1,
        ST_CMD      = 3'd2,
        ST_DEVSTATE = 3'd3,
        ST_NOSTOP   = 3'd4,
        ST_CRC      = 3'd5
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEVICE_ADDRESS   = 1'b0,
        REG_EXPECTED_COMMAND = 1'b1
    } cfg_reg_t;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    typedef struct packed {
        logic [7:0] device_state;
        status_t    status;
        logic [7:0] byte_index;
        logic [7:0] payload_byte;
        logic       kind;
    } result_t;

    // msb-first crc-8, one byte
    function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] v;
        v = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (v[7])
                v = {v[6:0], 1'b0} ^ CRC_POLY;
            else
                v = {v[6:0], 1'b0};
        end
        return v;
    endfunction

endpackage

### design/srd_parser.sv
// ----------------------------------------------------------------------------
// srd_parser
// Frame state machine, unescaping and running crc; one byte per cycle while in_fire is high.
// ----------------------------------------------------------------------------
module srd_parser (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_fire,
    input  logic [srd_pkg::RX_W-1:0]      rx_byte,
    input  logic                          cfg_fire,
    input  logic [srd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                    cfg_data,
    output logic                          res_valid,
    output srd_pkg::result_t              res
);
    import srd_pkg::*;

    phase_t     phase_reg, phase_next;
    logic       esc_reg, esc_next;
    logic [7:0] crc_reg, crc_next;
    logic [7:0] left_reg, left_next;
    logic [7:0] count_reg, count_next;
    logic [7:0] held_state_reg, held_state_next;
    logic [7:0] held_check_reg, held_check_next;
    logic [7:0] dev_addr_reg;
    logic [7:0] exp_cmd_reg;

    logic [7:0] v;
    logic [7:0] crc_fed;
    logic       is_esc;

    // escape flag is only ever set in payload or check phase
    assign v       = esc_reg ? (rx_byte ^ ESC_MASK) : rx_byte;
    assign crc_fed = crc_feed(crc_reg, v);
    assign is_esc  = !esc_reg && (rx_byte == ESC_BYTE);

    always_comb
    begin
        phase_next      = phase_reg;
        esc_next        = esc_reg;
        crc_next        = crc_reg;
        left_next       = left_reg;
        count_next      = count_reg;
        held_state_next = held_state_reg;
        held_check_next = held_check_reg;
        res_valid          = 1'b0;
        res.kind           = KIND_STATUS;
        res.payload_byte   = 8'h00;
        res.byte_index     = count_reg;
        res.status         = ST_OK;
        res.device_state   = held_state_reg;

        if (in_fire)
        begin
            case (phase_reg)
                PH_HUNT:
                begin
                    if (rx_byte == FLAG_BYTE)
                    begin
                        phase_next      = PH_ADDR;
                        esc_next        = 1'b0;
                        crc_next        = CRC_INIT;
                        left_next       = 8'h00;
                        count_next      = 8'h00;
                        held_state_next = 8'h00;
                        held_check_next = 8'h00;
                    end
                end
                PH_ADDR:
                begin
                    crc_next = crc_fed;
                    if (rx_byte != dev_addr_reg)
                    begin
                        res_valid  = 1'b1;
                        res.status = ST_ADDR;
                        phase_next = PH_HUNT;
                    end
                    else
                        phase_next = PH_CMD;
                end
                PH_CMD:
                begin
                    crc_next = crc_fed;
                    if (rx_byte != exp_cmd_reg)
                    begin
                        res_valid  = 1'b1;
                        res.status = ST_CMD;
                        phase_next = PH_HUNT;
                    end
                    else
                        phase_next = PH_STATE;
                end
                PH_STATE:
                begin
                    crc_next        = crc_fed;
                    held_state_next = rx_byte;
                    if (rx_byte != 8'h00)
                    begin
                        res_valid        = 1'b1;
                        res.status       = ST_DEVSTATE;
                        res.device_state = rx_byte;
                        phase_next       = PH_HUNT;
                    end
                    else
                        phase_next = PH_LEN;
                end
                PH_LEN:
                begin
                    crc_next   = crc_fed;
                    left_next  = rx_byte;
                    phase_next = (rx_byte == 8'h00) ? PH_CHECK : PH_DATA;
                end
                PH_DATA:
                begin
                    if (is_esc)
                        esc_next = 1'b1;
                    else
                    begin
                        esc_next         = 1'b0;
                        crc_next         = crc_fed;
                        res_valid        = 1'b1;
                        res.kind         = KIND_PAYLOAD;
                        res.payload_byte = v;
                        res.device_state = 8'h00;
                        count_next       = count_reg + 8'd1;
                        left_next        = left_reg - 8'd1;
                        if (left_reg == 8'd1)
                            phase_next = PH_CHECK;
                    end
                end
                PH_CHECK:
                begin
                    if (is_esc)
                        esc_next = 1'b1;
                    else
                    begin
                        esc_next        = 1'b0;
                        held_check_next = v;
                        phase_next      = PH_STOP;
                    end
                end
                default:
                begin
                    res_valid  = 1'b1;
                    phase_next = PH_HUNT;
                    if (rx_byte != FLAG_BYTE)
                        res.status = ST_NOSTOP;
                    else if (held_check_reg != crc_reg)
                        res.status = ST_CRC;
                    else
                        res.status = ST_OK;
                end
            endcase
            // any status sends the parser back to hunting
            if (res_valid && res.kind == KIND_STATUS)
                esc_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HUNT;
            esc_reg        <= 1'b0;
            crc_reg        <= CRC_INIT;
            left_reg       <= 8'h00;
            count_reg      <= 8'h00;
            held_state_reg <= 8'h00;
            held_check_reg <= 8'h00;
            dev_addr_reg   <= 8'h00;
            exp_cmd_reg    <= 8'h00;
        end
        else
        begin
            phase_reg      <= phase_next;
            esc_reg        <= esc_next;
            crc_reg        <= crc_next;
            left_reg       <= left_next;
            count_reg      <= count_next;
            held_state_reg <= held_state_next;
            held_check_reg <= held_check_next;
            if (cfg_fire && cfg_index == REG_DEVICE_ADDRESS)
                dev_addr_reg <= cfg_data;
            if (cfg_fire && cfg_index == REG_EXPECTED_COMMAND)
                exp_cmd_reg <= cfg_data;
        end
    end

    a_esc_phase: assert property (@(posedge clk) disable iff (!rst_n)
        esc_reg |-> (phase_reg == PH_DATA || phase_reg == PH_CHECK))
        else $error("escape pending outside payload or check");

    a_payload_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.kind == KIND_PAYLOAD) |-> (phase_reg == PH_DATA && left_reg != 8'h00))
        else $error("payload word outside payload phase");

    a_status_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.kind == KIND_STATUS) |=> (phase_reg == PH_HUNT && !esc_reg))
        else $error("status not followed by hunting");

endmodule

### design/srd_out_buf.sv
// ----------------------------------------------------------------------------
// srd_out_buf
// Result register with a skid stage, so input keeps flowing under stall until both are full.
// ----------------------------------------------------------------------------
module srd_out_buf (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             res_valid,
    input  srd_pkg::result_t res,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output srd_pkg::result_t out_res
);
    import srd_pkg::*;

    logic    main_valid_reg, main_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t main_reg, main_next;
    result_t skid_reg, skid_next;
    logic    pop;

    assign pop       = main_valid_reg && out_ready;
    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_res   = main_reg;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
            else if (res_valid)
                main_next = res;
            else
                main_valid_next = 1'b0;
        end
        else if (res_valid)
        begin
            if (!main_valid_reg)
            begin
                main_next       = res;
                main_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = res;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid word held with empty result register");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !skid_valid_reg)
        else $error("new word while both stages full");

    a_skid_moves_up: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && out_ready) |=> (main_valid_reg && !skid_valid_reg))
        else $error("skid word not moved up on drain");

endmodule

### design/shdlc_response_deframer.sv
// ----------------------------------------------------------------------------
// shdlc_response_deframer
// Byte-serial deframer for shdlc-style response frames with crc-8 check.
// ----------------------------------------------------------------------------
// Takes one received byte per cycle on the slave stream while s_tready is high,
// and gives one word per payload byte plus one status word per frame on the
// master stream. Each byte is handled combinationally by the frame state machine
// and an unrolled crc-8 update, and the result lands in a result register backed
// by a skid stage, so s_tready only drops after two result words are held under
// back-pressure. Configuration writes are always accepted and take effect from
// the next byte on.
module shdlc_response_deframer (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [srd_pkg::RX_W-1:0]        s_tdata,   // [7:0] rx_byte
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [7:0] payload_byte, [15:8] byte_index, [18:16] status, [26:19] device_state
    output logic [srd_pkg::M_DATA_W-1:0]    m_tdata,
    output logic [0:0]                      m_tuser,   // [0] kind
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [srd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [7:0]                      cfg_data
);
    import srd_pkg::*;

    logic    in_fire;
    logic    res_valid;
    result_t res;
    result_t out_res;

    assign in_fire   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    srd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .rx_byte   (s_tdata),
        .cfg_fire  (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .res_valid (res_valid),
        .res       (res)
    );

    srd_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = {5'b0, out_res.device_state, out_res.status,
                      out_res.byte_index, out_res.payload_byte};
    assign m_tuser = out_res.kind;

endmodule

### verif/srd_deframe_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// srd_deframe_checker
// Watches the byte, result and register channels of the response deframer,
// predicts every result word from the accepted bytes and compares in order.
// ----------------------------------------------------------------------------
module srd_deframe_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [srd_pkg::RX_W-1:0]        s_tdata,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [srd_pkg::M_DATA_W-1:0]    m_tdata,
    input  logic [0:0]                      m_tuser,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [srd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [7:0]                      cfg_data,
    output int                              fail_count,
    output int                              words_due,
    output int                              payload_words,
    output int                              status_words,
    output logic [5:0]                      status_seen
);
    import srd_pkg::*;

    // predicted copy of the frame parser
    phase_t     rx_phase;
    logic       esc_armed;
    logic [7:0] crc_acc;
    logic [7:0] bytes_to_go;
    logic [7:0] pay_count;
    logic [7:0] frame_dev_state;
    logic [7:0] frame_check;
    logic [7:0] match_addr;
    logic [7:0] match_cmd;

    result_t    deframed_due[$];
    result_t    want;

    function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] r;
        r = crc ^ b;
        repeat (8)
        begin
            r = r[7] ? ({r[6:0], 1'b0} ^ 8'h31) : {r[6:0], 1'b0};
        end
        return r;
    endfunction

    function automatic void close_frame(input status_t st);
        result_t w;
        w = '0;
        w.kind         = KIND_STATUS;
        w.byte_index   = pay_count;
        w.status       = st;
        w.device_state = frame_dev_state;
        deframed_due.push_back(w);
        rx_phase  = PH_HUNT;
        esc_armed = 1'b0;
    endfunction

    function automatic void deframe_byte(input logic [7:0] b);
        logic [7:0] v;
        result_t    w;
        w = '0;
        case (rx_phase)
            PH_HUNT:
            begin
                if (b == FLAG_BYTE)
                begin
                    rx_phase        = PH_ADDR;
                    esc_armed       = 1'b0;
                    crc_acc         = CRC_INIT;
                    bytes_to_go     = 8'h00;
                    pay_count       = 8'h00;
                    frame_dev_state = 8'h00;
                    frame_check     = 8'h00;
                end
            end
            PH_ADDR:
            begin
                crc_acc = crc8_next(crc_acc, b);
                if (b != match_addr)
                    close_frame(ST_ADDR);
                else
                    rx_phase = PH_CMD;
            end
            PH_CMD:
            begin
                crc_acc = crc8_next(crc_acc, b);
                if (b != match_cmd)
                    close_frame(ST_CMD);
                else
                    rx_phase = PH_STATE;
            end
            PH_STATE:
            begin
                crc_acc         = crc8_next(crc_acc, b);
                frame_dev_state = b;
                if (b != 8'h00)
                    close_frame(ST_DEVSTATE);
                else
                    rx_phase = PH_LEN;
            end
            PH_LEN:
            begin
                crc_acc     = crc8_next(crc_acc, b);
                bytes_to_go = b;
                rx_phase    = (b == 8'h00) ? PH_CHECK : PH_DATA;
            end
            PH_DATA:
            begin
                if (!esc_armed && b == ESC_BYTE)
                begin
                    esc_armed = 1'b1;
                end
                else
                begin
                    v         = esc_armed ? (b ^ ESC_MASK) : b;
                    esc_armed = 1'b0;
                    crc_acc   = crc8_next(crc_acc, v);
                    w.kind         = KIND_PAYLOAD;
                    w.payload_byte = v;
                    w.byte_index   = pay_count;
                    deframed_due.push_back(w);
                    pay_count   = pay_count + 8'd1;
                    bytes_to_go = bytes_to_go - 8'd1;
                    if (bytes_to_go == 8'h00)
                        rx_phase = PH_CHECK;
                end
            end
            PH_CHECK:
            begin
                if (!esc_armed && b == ESC_BYTE)
                begin
                    esc_armed = 1'b1;
                end
                else
                begin
                    frame_check = esc_armed ? (b ^ ESC_MASK) : b;
                    esc_armed   = 1'b0;
                    rx_phase    = PH_STOP;
                end
            end
            default:
            begin
                // stop position: a missing flag wins over the crc verdict
                if (b != FLAG_BYTE)
                    close_frame(ST_NOSTOP);
                else
                    close_frame((frame_check == crc_acc) ? ST_OK : ST_CRC);
            end
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [31:0] exp_v,
                                        input logic [31:0] got_v);
        if (exp_v !== got_v)
        begin
            fail_count++;
            $display("%0t srd check: %s expected %h, got %h", $time, name, exp_v, got_v);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_phase        = PH_HUNT;
            esc_armed       = 1'b0;
            crc_acc         = CRC_INIT;
            bytes_to_go     = 8'h00;
            pay_count       = 8'h00;
            frame_dev_state = 8'h00;
            frame_check     = 8'h00;
            match_addr      = 8'h00;
            match_cmd       = 8'h00;
            deframed_due.delete();
            fail_count      = 0;
            payload_words   = 0;
            status_words    = 0;
            status_seen     = '0;
            words_due      <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (deframed_due.size() == 0)
                begin
                    fail_count++;
                    $display("%0t srd check: expected no word, got kind %0d data %h",
                             $time, m_tuser, m_tdata);
                end
                else
                begin
                    want = deframed_due.pop_front();
                    check_field("kind", 32'(want.kind), 32'(m_tuser[0]));
                    check_field("payload_byte", 32'(want.payload_byte), 32'(m_tdata[7:0]));
                    check_field("byte_index", 32'(want.byte_index), 32'(m_tdata[15:8]));
                    check_field("status", 32'(want.status), 32'(m_tdata[18:16]));
                    check_field("device_state", 32'(want.device_state),
                                32'(m_tdata[26:19]));
                    check_field("tdata padding", 32'h0, 32'(m_tdata[31:27]));
                    if (want.kind == KIND_STATUS)
                    begin
                        status_words++;
                        status_seen[want.status] = 1'b1;
                    end
                    else
                    begin
                        payload_words++;
                    end
                end
            end
            // a byte taken at the same edge as a register write still sees the old value
            if (s_tvalid && s_tready)
                deframe_byte(s_tdata);
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_DEVICE_ADDRESS)
                    match_addr = cfg_data;
                else
                    match_cmd = cfg_data;
            end
            words_due <= deframed_due.size();
        end
    end

endmodule

### verif/tb_shdlc_response_deframer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_shdlc_response_deframer
// Stimulus and verdict for the response deframer.
// ----------------------------------------------------------------------------
// Drives short directed frames and then random well-formed, corrupted and
// broken response frames under six address/command filter settings, with
// random idling on both streams, one long output stall and a quiet final part.
// A checker beside the block predicts and compares every result word.
module tb_shdlc_response_deframer;
    import srd_pkg::*;

    localparam int HOLD_CYCLES  = 400;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 6;
    localparam int PHASE_BYTES  = 240;

    typedef enum logic [1:0] {
        STY_MIN,    // escape only flag and escape values
        STY_HEAVY,  // escape everything except 0x7e, which goes raw
        STY_MIX     // random extra escapes and raw flags
    } esc_style_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [RX_W-1:0]        s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_DATA_W-1:0]    m_tdata;
    logic [0:0]             m_tuser;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [7:0]             cfg_data;

    int         fail_count;
    int         words_due;
    int         payload_words;
    int         status_words;
    logic [5:0] status_seen;

    logic [7:0] line_bytes[$];
    logic [7:0] payload_bytes[$];
    logic [7:0] filt_addr;
    logic [7:0] filt_cmd;
    int         bytes_sent;
    int         bytes_total;
    bit         tx_gaps;
    bit         rx_stalls;
    bit         hold_long;
    int         quiet_cycles;

    shdlc_response_deframer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    srd_deframe_checker chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .words_due     (words_due),
        .payload_words (payload_words),
        .status_words  (status_words),
        .status_seen   (status_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // crc over a frame being built, msb first
    function automatic logic [7:0] frame_crc_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] r;
        r = crc ^ b;
        repeat (8)
        begin
            r = r[7] ? ({r[6:0], 1'b0} ^ CRC_POLY) : {r[6:0], 1'b0};
        end
        return r;
    endfunction

    function automatic void put_data(input logic [7:0] v, input esc_style_t sty);
        bit esc_it;
        bit raw_flag;
        raw_flag = (v == FLAG_BYTE) && (sty == STY_HEAVY ||
                   (sty == STY_MIX && $urandom_range(0, 3) == 0));
        esc_it = (v == FLAG_BYTE) || (v == ESC_BYTE) || (sty == STY_HEAVY) ||
                 (sty == STY_MIX && $urandom_range(0, 7) == 0);
        if (!raw_flag && esc_it)
        begin
            line_bytes.push_back(ESC_BYTE);
            line_bytes.push_back(v ^ ESC_MASK);
        end
        else
        begin
            line_bytes.push_back(v);
        end
    endfunction

    // appends one frame carrying payload_bytes to line_bytes
    function automatic void pack_frame(input logic [7:0] addr, input logic [7:0] cmd,
                                       input logic [7:0] dev_state, input esc_style_t sty,
                                       input bit bad_crc, input bit no_stop);
        logic [7:0] acc;
        logic [7:0] len;
        logic [7:0] flip;
        logic [7:0] tail;
        len = 8'(payload_bytes.size());
        acc = CRC_INIT;
        acc = frame_crc_step(acc, addr);
        acc = frame_crc_step(acc, cmd);
        acc = frame_crc_step(acc, dev_state);
        acc = frame_crc_step(acc, len);
        line_bytes.push_back(FLAG_BYTE);
        line_bytes.push_back(addr);
        line_bytes.push_back(cmd);
        line_bytes.push_back(dev_state);
        line_bytes.push_back(len);
        foreach (payload_bytes[i])
        begin
            acc = frame_crc_step(acc, payload_bytes[i]);
            put_data(payload_bytes[i], sty);
        end
        flip = 8'($urandom_range(1, 255));
        put_data(bad_crc ? (acc ^ flip) : acc, sty);
        tail = 8'($urandom_range(0, 255));
        if (tail == FLAG_BYTE)
            tail = 8'h00;
        line_bytes.push_back(no_stop ? tail : FLAG_BYTE);
    endfunction

    task automatic send_byte(input logic [7:0] b);
        if (tx_gaps && $urandom_range(0, 7) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge clk); while (!s_tready);
        bytes_total++;
    endtask

    task automatic send_line(input bit counted);
        foreach (line_bytes[i])
            send_byte(line_bytes[i]);
        if (counted)
            bytes_sent += line_bytes.size();
        line_bytes.delete();
    endtask

    task automatic settle_output;
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (words_due != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic config_filter(input logic [7:0] addr, input logic [7:0] cmd);
        cfg_valid <= 1'b1;
        cfg_index <= REG_DEVICE_ADDRESS;
        cfg_data  <= addr;
        do @(posedge clk); while (!cfg_ready);
        cfg_index <= REG_EXPECTED_COMMAND;
        cfg_data  <= cmd;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
        filt_addr = addr;
        filt_cmd  = cmd;
    endtask

    task automatic random_frame(input int len_force);
        int         len;
        int         pick;
        logic [7:0] a;
        logic [7:0] c;
        logic [7:0] d;
        logic [7:0] b;
        payload_bytes.delete();
        if ($urandom_range(0, 4) == 0)
        begin
            // line noise ahead of the frame, skipped while hunting
            repeat ($urandom_range(1, 3))
            begin
                b = 8'($urandom_range(0, 255));
                line_bytes.push_back((b == FLAG_BYTE) ? 8'h00 : b);
            end
            send_line(1'b0);
        end
        if (len_force >= 0)
            len = len_force;
        else if ($urandom_range(0, 99) == 0)
            len = $urandom_range(41, 255);
        else if ($urandom_range(0, 3) == 0)
            len = $urandom_range(7, 40);
        else
            len = $urandom_range(0, 6);
        repeat (len)
        begin
            pick = $urandom_range(0, 15);
            if (pick == 0)
                b = FLAG_BYTE;
            else if (pick == 1)
                b = ESC_BYTE;
            else
                b = 8'($urandom_range(0, 255));
            payload_bytes.push_back(b);
        end
        a = filt_addr;
        c = filt_cmd;
        d = 8'h00;
        b = 8'($urandom_range(1, 255));
        pick = $urandom_range(0, 99);
        if (pick < 97)
        begin
            if (pick >= 86 && pick < 90)
                a = a ^ b;
            else if (pick >= 90 && pick < 94)
                c = c ^ b;
            else if (pick >= 94)
                d = b;
            pack_frame(a, c, d, STY_MIX, pick >= 72 && pick < 80, pick >= 80 && pick < 86);
            // early rejections: sometimes leave off the trailing flag
            if (pick >= 86 && $urandom_range(0, 1) == 0)
                void'(line_bytes.pop_back());
        end
        else
        begin
            // start flag followed by garbage
            line_bytes.push_back(FLAG_BYTE);
            repeat ($urandom_range(1, 20))
                line_bytes.push_back(8'($urandom_range(0, 255)));
        end
        send_line(1'b1);
    endtask

    // receiver side
    initial
    begin
        bit held_once;
        held_once = 1'b0;
        m_tready  = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_long && !held_once)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                held_once = 1'b1;
            end
            else if (rx_stalls && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
        end
    end

    // watchdog on cycles with no word moving on any channel
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial
    begin
        int         phase_start;
        logic [7:0] set_addr;
        logic [7:0] set_cmd;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        cfg_valid    = 1'b0;
        cfg_index    = REG_DEVICE_ADDRESS;
        cfg_data     = 8'h00;
        hold_long    = 1'b0;
        tx_gaps      = 1'b1;
        rx_stalls    = 1'b1;
        bytes_sent   = 0;
        bytes_total  = 0;
        filt_addr    = 8'h00;
        filt_cmd     = 8'h00;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: noise, each early rejection, then whole frames
        line_bytes = {8'h00, 8'hFF,
                      FLAG_BYTE, 8'hFF,
                      FLAG_BYTE, 8'h00, 8'hFF,
                      FLAG_BYTE, 8'h00, 8'h00, 8'h80};
        send_line(1'b1);
        payload_bytes.delete();
        pack_frame(8'h00, 8'h00, 8'h00, STY_HEAVY, 1'b0, 1'b0);
        // double escapes and a raw flag inside the payload
        payload_bytes = {8'h5D, FLAG_BYTE, 8'h5E, 8'hFF};
        pack_frame(8'h00, 8'h00, 8'h00, STY_HEAVY, 1'b0, 1'b0);
        payload_bytes.delete();
        pack_frame(8'h00, 8'h00, 8'h00, STY_MIN, 1'b0, 1'b1);
        payload_bytes = {8'h00};
        pack_frame(8'h00, 8'h00, 8'h00, STY_MIN, 1'b1, 1'b0);
        send_line(1'b1);

        for (int p = 0; p < 6; p++)
        begin
            settle_output();
            set_addr = 8'($urandom_range(0, 255));
            set_cmd  = 8'($urandom_range(0, 255));
            case (p)
                0: begin set_addr = 8'hFF; set_cmd = 8'hFF; end
                1: begin set_addr = FLAG_BYTE; set_cmd = ESC_BYTE; end
                2: begin set_addr = 8'h00; set_cmd = 8'h00; end
                4: begin set_addr = ESC_BYTE; set_cmd = FLAG_BYTE; end
                default: ;
            endcase
            config_filter(set_addr, set_cmd);
            tx_gaps   = (p != 2) && (p != 5);
            rx_stalls = (p != 2) && (p != 5);
            phase_start = bytes_sent;
            if (p == 1)
            begin
                // long output stall while a big frame keeps coming
                hold_long = 1'b1;
                random_frame(40);
            end
            if (p == 3)
                random_frame(255);
            while (bytes_sent - phase_start < PHASE_BYTES)
                random_frame(-1);
        end
        settle_output();

        $display("tb: %0d bytes over six filter settings, %0d payload and %0d status words",
                 bytes_total, payload_words, status_words);
        $display("tb: status codes seen (bit per code, ok lowest): %b", status_seen);
        if (fail_count == 0 && words_due == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

### sim.f
design/srd_pkg.sv
design/srd_parser.sv
design/srd_out_buf.sv
design/shdlc_response_deframer.sv
verif/srd_deframe_checker.sv
verif/tb_shdlc_response_deframer.sv
